FILE: design/qlg_pkg.sv
// Shared types, codes and constants of the grid Q-learning update block.
package qlg_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int OUT_VALUE_W = 16;
   localparam int RATE_W      = 9;
   localparam int RATE_PROD_W = 17;
   localparam int RATE_SHIFT  = 16;

   localparam logic [RATE_W-1:0] RATE_ONE = 9'd256;

   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] MOVE_UP    = 2'd0;
   localparam logic [1:0] MOVE_RIGHT = 2'd1;
   localparam logic [1:0] MOVE_DOWN  = 2'd2;
   localparam logic [1:0] MOVE_LEFT  = 2'd3;

   localparam logic [2:0] STAT_UPDATED   = 3'd0;
   localparam logic [2:0] STAT_REJECTED  = 3'd1;
   localparam logic [2:0] STAT_RESTARTED = 3'd2;
   localparam logic [2:0] STAT_BAD_CELL  = 3'd3;
   localparam logic [2:0] STAT_DONE      = 3'd4;

   // ascending target cell: up, left, right, down
   localparam logic [1:0] SCAN_ORDER [4] = '{MOVE_UP, MOVE_LEFT, MOVE_RIGHT, MOVE_DOWN};

   typedef enum logic [2:0] {
      CSR_GRID_ROWS  = 3'd0,
      CSR_GRID_COLS  = 3'd1,
      CSR_GOAL_CELL  = 3'd2,
      CSR_LEARN_RATE = 3'd3,
      CSR_DISCOUNT   = 3'd4,
      CSR_SEED_VALUE = 3'd5
   } csr_index_type;

   localparam logic [3:0]  RST_GRID_ROWS  = 4'd2;
   localparam logic [3:0]  RST_GRID_COLS  = 4'd3;
   localparam logic [5:0]  RST_GOAL_CELL  = 6'd2;
   localparam logic [8:0]  RST_LEARN_RATE = 9'd26;
   localparam logic [8:0]  RST_DISCOUNT   = 9'd230;
   localparam logic [15:0] RST_SEED_VALUE = 16'd25600;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] move;
      logic [5:0] restart_cell;
      logic [5:0] query_cell;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  agent_cell;
      logic [15:0] value_out;
      logic [5:0]  best_next;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  grid_rows;
      logic [3:0]  grid_cols;
      logic [5:0]  goal_cell;
      logic [8:0]  learn_rate;
      logic [8:0]  discount;
      logic [15:0] seed_value;
   } csr_regs_type;

   typedef enum logic [1:0] {
      LOC_CUR     = 2'd0,
      LOC_RESTART = 2'd1,
      LOC_QUERY   = 2'd2
   } loc_src_type;

   typedef enum logic [1:0] {
      VAL_ZERO = 2'd0,
      VAL_BEST = 2'd1,
      VAL_NEW  = 2'd2
   } val_sel_type;

   typedef struct packed {
      logic        accept;
      logic        sw_start;
      logic        sw_run;
      logic        sw_seed;
      logic        loc_load;
      loc_src_type loc_sel;
      logic        sc_load;
      logic        sc_from_tgt;
      logic        scan_start;
      logic        scan_issue;
      logic        mul_run;
      logic        rd_upd;
      logic        upd_write;
      logic        cur_set;
      logic        cur_from_tgt;
      logic        rsp_load;
      logic [2:0]  rsp_status;
      val_sel_type rsp_vsel;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       loc_done;
      logic       in_grid;
      logic       cur_is_goal;
      logic       move_ok;
      logic       tgt_is_goal;
      logic       sw_last;
      logic       scan_last;
   } dp_stat_type;

endpackage

FILE: design/qlg_csr.sv
// Configuration registers of the grid Q-learning update block.
module qlg_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [qlg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qlg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output qlg_pkg::csr_regs_type           regs
);
   import qlg_pkg::*;

   csr_regs_type regs_ff;
   csr_regs_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_ROWS:  regs_in.grid_rows  = csr_wdata[3:0];
            CSR_GRID_COLS:  regs_in.grid_cols  = csr_wdata[3:0];
            CSR_GOAL_CELL:  regs_in.goal_cell  = csr_wdata[5:0];
            CSR_LEARN_RATE: regs_in.learn_rate = csr_wdata[8:0];
            CSR_DISCOUNT:   regs_in.discount   = csr_wdata[8:0];
            CSR_SEED_VALUE: regs_in.seed_value = csr_wdata[15:0];
            default:        regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.grid_rows  <= RST_GRID_ROWS;
         regs_ff.grid_cols  <= RST_GRID_COLS;
         regs_ff.goal_cell  <= RST_GOAL_CELL;
         regs_ff.learn_rate <= RST_LEARN_RATE;
         regs_ff.discount   <= RST_DISCOUNT;
         regs_ff.seed_value <= RST_SEED_VALUE;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_ready = 1'b1;
   assign regs      = regs_ff;

endmodule

FILE: design/qlg_ctrl.sv
// Sequencing state machine of the grid Q-learning update block.
module qlg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_command,
   input  qlg_pkg::dp_stat_type stat,
   output qlg_pkg::dp_cmd_type  cmd,
   output logic                 busy
);
   import qlg_pkg::*;

   typedef enum logic [8:0] {
      S_CLEAR    = 9'b000000001,
      S_IDLE     = 9'b000000010,
      S_SWEEP    = 9'b000000100,
      S_LOC_A    = 9'b000001000,
      S_LOC_R    = 9'b000010000,
      S_SCAN     = 9'b000100000,
      S_SCAN_END = 9'b001000000,
      S_MUL      = 9'b010000000,
      S_UPD      = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.sw_run = 1'b1;
            if (stat.sw_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               unique case (req_command)
                  CMD_INIT: begin
                     cmd.sw_start = 1'b1;
                     state_in     = S_SWEEP;
                  end
                  CMD_STEP: begin
                     cmd.loc_load = 1'b1;
                     cmd.loc_sel  = LOC_CUR;
                     state_in     = S_LOC_A;
                  end
                  CMD_QUERY: begin
                     cmd.loc_load = 1'b1;
                     cmd.loc_sel  = LOC_QUERY;
                     state_in     = S_LOC_A;
                  end
                  default: begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STAT_REJECTED;
                     cmd.rsp_vsel   = VAL_ZERO;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            cmd.sw_run  = 1'b1;
            cmd.sw_seed = 1'b1;
            if (stat.sw_last) begin
               cmd.loc_load = 1'b1;
               cmd.loc_sel  = LOC_RESTART;
               state_in     = S_LOC_R;
            end
         end
         S_LOC_A: begin
            if (stat.loc_done) begin
               if (!stat.in_grid) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = STAT_BAD_CELL;
                  state_in       = S_IDLE;
               end else if (stat.command == CMD_QUERY) begin
                  cmd.sc_load    = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end else if (stat.cur_is_goal) begin
                  cmd.loc_load = 1'b1;
                  cmd.loc_sel  = LOC_RESTART;
                  state_in     = S_LOC_R;
               end else if (!stat.move_ok) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = STAT_REJECTED;
                  state_in       = S_IDLE;
               end else begin
                  cmd.sc_load     = 1'b1;
                  cmd.sc_from_tgt = 1'b1;
                  cmd.scan_start  = 1'b1;
                  state_in        = stat.tgt_is_goal ? S_MUL : S_SCAN;
               end
            end
         end
         S_LOC_R: begin
            if (stat.loc_done) begin
               cmd.rsp_load = 1'b1;
               if (stat.in_grid) begin
                  cmd.cur_set    = 1'b1;
                  cmd.rsp_status = (stat.command == CMD_INIT) ? STAT_DONE : STAT_RESTARTED;
               end else begin
                  cmd.rsp_status = STAT_BAD_CELL;
               end
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.scan_last) state_in = S_SCAN_END;
         end
         S_SCAN_END: begin
            if (stat.command == CMD_QUERY) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STAT_DONE;
               cmd.rsp_vsel   = VAL_BEST;
               state_in       = S_IDLE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_run = 1'b1;
            cmd.rd_upd  = 1'b1;
            state_in    = S_UPD;
         end
         S_UPD: begin
            cmd.upd_write    = 1'b1;
            cmd.cur_set      = 1'b1;
            cmd.cur_from_tgt = 1'b1;
            cmd.rsp_load     = 1'b1;
            cmd.rsp_status   = STAT_UPDATED;
            cmd.rsp_vsel     = VAL_NEW;
            state_in         = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> state_ff == S_IDLE)
      else $error("controller not idle after a result");

   a_upd_after_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPD |-> $past(state_ff == S_MUL))
      else $error("table update without multiply");

endmodule

FILE: design/qlg_dpath.sv
// Datapath of the grid Q-learning update block: Q table, locate, scan and update arithmetic.
module qlg_dpath #(
   parameter int MAX_DIM    = 8,
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  qlg_pkg::req_type      req_in,
   input  qlg_pkg::csr_regs_type regs,
   input  qlg_pkg::dp_cmd_type   cmd,
   output qlg_pkg::dp_stat_type  stat,
   output logic                  rsp_valid,
   output qlg_pkg::rsp_type      rsp_out
);
   import qlg_pkg::*;

   localparam int CELLS  = MAX_DIM * MAX_DIM;
   localparam int DEPTH  = 4 * CELLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CELL_W = (CELLS > 64) ? $clog2(CELLS) : 6;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int MUL_W  = RATE_PROD_W + VALUE_BITS;
   localparam int INCR_W = MUL_W - RATE_SHIFT;
   localparam int SUM_W  = VALUE_BITS + 2;

   function automatic logic nb_ok(input logic [1:0] m, input logic [CELL_W-1:0] r,
                                  input logic [CELL_W-1:0] c, input logic [CELL_W-1:0] nr,
                                  input logic [CELL_W-1:0] nc);
      logic ok;
      unique case (m)
         MOVE_UP:    ok = (r != '0);
         MOVE_RIGHT: ok = ((c + 1'b1) < nc);
         MOVE_DOWN:  ok = ((r + 1'b1) < nr);
         MOVE_LEFT:  ok = (c != '0);
         default:    ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic [CELL_W-1:0] nb_cell(input logic [1:0] m,
                                                 input logic [CELL_W-1:0] src,
                                                 input logic [CELL_W-1:0] nc);
      logic [CELL_W-1:0] t;
      unique case (m)
         MOVE_UP:    t = src - nc;
         MOVE_RIGHT: t = src + 1'b1;
         MOVE_DOWN:  t = src + nc;
         MOVE_LEFT:  t = src - 1'b1;
         default:    t = src;
      endcase
      return t;
   endfunction

   // clamped configuration
   logic [DIM_W-1:0]  rows_c, cols_c;
   logic [CELL_W-1:0] rows_x, cols_x, goal_x;
   logic [RATE_W-1:0] alpha_c, gamma_c;
   logic [VALUE_BITS+15:0] seed_ext;
   logic [VALUE_BITS-1:0]  seed_v;

   always_comb begin
      if (regs.grid_rows == '0)          rows_c = DIM_W'(1);
      else if (int'(regs.grid_rows) > MAX_DIM) rows_c = DIM_W'(MAX_DIM);
      else                               rows_c = DIM_W'(regs.grid_rows);
      if (regs.grid_cols == '0)          cols_c = DIM_W'(1);
      else if (int'(regs.grid_cols) > MAX_DIM) cols_c = DIM_W'(MAX_DIM);
      else                               cols_c = DIM_W'(regs.grid_cols);
   end

   assign rows_x   = CELL_W'(rows_c);
   assign cols_x   = CELL_W'(cols_c);
   assign goal_x   = CELL_W'(regs.goal_cell);
   assign alpha_c  = (regs.learn_rate > RATE_ONE) ? RATE_ONE : regs.learn_rate;
   assign gamma_c  = (regs.discount > RATE_ONE) ? RATE_ONE : regs.discount;
   assign seed_ext = {VALUE_BITS'(0), regs.seed_value};
   assign seed_v   = seed_ext[VALUE_BITS-1:0];

   // latched transaction
   req_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_in;
   end

   // current cell
   logic [CELL_W-1:0] cur_cell_ff, cur_cell_in;
   logic [CELL_W-1:0] sc_cell_ff, sc_row_ff, sc_col_ff;

   always_comb begin
      cur_cell_in = cur_cell_ff;
      if (cmd.cur_set) begin
         cur_cell_in = cmd.cur_from_tgt ? sc_cell_ff : CELL_W'(req_ff.restart_cell);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cur_cell_ff <= '0;
      else       cur_cell_ff <= cur_cell_in;
   end

   // locate: row and column by repeated subtraction of the column count
   logic [CELL_W-1:0] loc_cell_ff, loc_rem_ff, loc_row_ff;
   logic [CELL_W-1:0] loc_op;
   logic              loc_done;

   always_comb begin
      case (cmd.loc_sel)
         LOC_CUR:     loc_op = cur_cell_ff;
         LOC_RESTART: loc_op = CELL_W'(req_ff.restart_cell);
         LOC_QUERY:   loc_op = CELL_W'(req_in.query_cell);
         default:     loc_op = cur_cell_ff;
      endcase
   end

   assign loc_done = (loc_rem_ff < cols_x) || (loc_row_ff == rows_x);

   always_ff @(posedge clock) begin
      if (cmd.loc_load) begin
         loc_cell_ff <= loc_op;
         loc_rem_ff  <= loc_op;
         loc_row_ff  <= '0;
      end else if (!loc_done) begin
         loc_rem_ff <= loc_rem_ff - cols_x;
         loc_row_ff <= loc_row_ff + 1'b1;
      end
   end

   // move target of the located cell
   logic              tgt_ok;
   logic [CELL_W-1:0] tgt_cell, tgt_row, tgt_col;

   always_comb begin
      tgt_ok   = nb_ok(req_ff.move, loc_row_ff, loc_rem_ff, rows_x, cols_x);
      tgt_cell = nb_cell(req_ff.move, loc_cell_ff, cols_x);
      tgt_row  = loc_row_ff;
      tgt_col  = loc_rem_ff;
      unique case (req_ff.move)
         MOVE_UP:    tgt_row = loc_row_ff - 1'b1;
         MOVE_RIGHT: tgt_col = loc_rem_ff + 1'b1;
         MOVE_DOWN:  tgt_row = loc_row_ff + 1'b1;
         MOVE_LEFT:  tgt_col = loc_rem_ff - 1'b1;
         default:    tgt_row = loc_row_ff;
      endcase
   end

   // scan of the four moves of one cell
   logic [ADDR_W-1:0]     upd_addr_ff;
   logic [1:0]            k_ff;
   logic [1:0]            sc_move;
   logic                  sc_ok;
   logic [CELL_W-1:0]     sc_tgt;
   logic [ADDR_W-1:0]     scan_addr;
   logic                  cmp_ff, cmp_ok_ff;
   logic [CELL_W-1:0]     cmp_tgt_ff;
   logic [VALUE_BITS-1:0] rd_ff;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic [CELL_W-1:0]     best_tgt_ff, best_tgt_in;

   always_ff @(posedge clock) begin
      if (cmd.sc_load) begin
         if (cmd.sc_from_tgt) begin
            sc_cell_ff  <= tgt_cell;
            sc_row_ff   <= tgt_row;
            sc_col_ff   <= tgt_col;
            upd_addr_ff <= ADDR_W'({loc_cell_ff, req_ff.move});
         end else begin
            sc_cell_ff <= loc_cell_ff;
            sc_row_ff  <= loc_row_ff;
            sc_col_ff  <= loc_rem_ff;
         end
      end
   end

   assign sc_move   = SCAN_ORDER[k_ff];
   assign sc_ok     = nb_ok(sc_move, sc_row_ff, sc_col_ff, rows_x, cols_x);
   assign sc_tgt    = nb_cell(sc_move, sc_cell_ff, cols_x);
   assign scan_addr = ADDR_W'({sc_cell_ff, sc_move});

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= '0;
         cmp_ff <= 1'b0;
      end else begin
         if (cmd.scan_start)      k_ff <= '0;
         else if (cmd.scan_issue) k_ff <= k_ff + 1'b1;
         cmp_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      cmp_ok_ff  <= sc_ok;
      cmp_tgt_ff <= sc_tgt;
   end

   always_comb begin
      best_in     = best_ff;
      best_tgt_in = best_tgt_ff;
      if (cmd.scan_start) begin
         best_in     = '0;
         best_tgt_in = '0;
      end else if (cmp_ff && cmp_ok_ff && (rd_ff > best_ff)) begin
         best_in     = rd_ff;
         best_tgt_in = cmp_tgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_tgt_ff <= best_tgt_in;
   end

   // table sweep for init and the clearing pass
   logic [ADDR_W-1:0]     sw_addr_ff;
   logic [CELL_W-1:0]     sw_cell_ff, sw_row_ff, sw_col_ff;
   logic [1:0]            sw_move;
   logic                  sw_last;
   logic                  sw_hit;
   logic [VALUE_BITS-1:0] sw_data;

   assign sw_move = sw_addr_ff[1:0];
   assign sw_last = (sw_addr_ff == ADDR_W'(DEPTH - 1));
   assign sw_hit  = cmd.sw_seed && (sw_row_ff < rows_x)
                    && nb_ok(sw_move, sw_row_ff, sw_col_ff, rows_x, cols_x)
                    && (nb_cell(sw_move, sw_cell_ff, cols_x) == goal_x);
   assign sw_data = sw_hit ? seed_v : '0;

   always_ff @(posedge clock) begin
      if (reset || cmd.sw_start) begin
         sw_addr_ff <= '0;
         sw_cell_ff <= '0;
         sw_row_ff  <= '0;
         sw_col_ff  <= '0;
      end else if (cmd.sw_run) begin
         sw_addr_ff <= sw_addr_ff + 1'b1;
         if (sw_move == MOVE_LEFT) begin
            sw_cell_ff <= sw_cell_ff + 1'b1;
            if ((sw_col_ff + 1'b1) == cols_x) begin
               sw_col_ff <= '0;
               sw_row_ff <= sw_row_ff + 1'b1;
            end else begin
               sw_col_ff <= sw_col_ff + 1'b1;
            end
         end
      end
   end

   // update arithmetic
   logic [RATE_PROD_W-1:0] prod_ff;
   logic [MUL_W-1:0]       mul_full;
   logic [INCR_W-1:0]      incr_ff;
   logic [SUM_W-1:0]       sum;
   logic [VALUE_BITS-1:0]  nv;

   assign mul_full = MUL_W'(prod_ff) * MUL_W'(best_ff);
   assign sum      = SUM_W'(rd_ff) + SUM_W'(incr_ff);
   assign nv       = (sum[SUM_W-1:VALUE_BITS] != '0) ? '1 : sum[VALUE_BITS-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= RATE_PROD_W'(alpha_c) * RATE_PROD_W'(gamma_c);
      if (cmd.mul_run) incr_ff <= mul_full[MUL_W-1:RATE_SHIFT];
   end

   // Q table
   logic [VALUE_BITS-1:0] q_mem [DEPTH];
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
   logic [VALUE_BITS-1:0] mem_wdata;

   assign mem_we    = cmd.sw_run || cmd.upd_write;
   assign mem_waddr = cmd.upd_write ? upd_addr_ff : sw_addr_ff;
   assign mem_wdata = cmd.upd_write ? nv : sw_data;
   assign mem_raddr = cmd.rd_upd ? upd_addr_ff : scan_addr;

   always_ff @(posedge clock) begin
      if (mem_we) q_mem[mem_waddr] <= mem_wdata;
      rd_ff <= q_mem[mem_raddr];
   end

   // result register
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   logic [VALUE_BITS-1:0]  val_sel;
   logic [VALUE_BITS+15:0] val_ext;

   always_comb begin
      case (cmd.rsp_vsel)
         VAL_BEST: val_sel = best_in;
         VAL_NEW:  val_sel = nv;
         default:  val_sel = '0;
      endcase
   end

   assign val_ext = {16'b0, val_sel};

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.rsp_load;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.status     <= cmd.rsp_status;
         rsp_ff.agent_cell <= cur_cell_in[5:0];
         rsp_ff.value_out  <= val_ext[OUT_VALUE_W-1:0];
         rsp_ff.best_next  <= (cmd.rsp_vsel == VAL_BEST) ? best_tgt_in[5:0] : 6'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;

   assign stat.command     = req_ff.command;
   assign stat.loc_done    = loc_done;
   assign stat.in_grid     = (loc_row_ff < rows_x);
   assign stat.cur_is_goal = (cur_cell_ff == goal_x);
   assign stat.move_ok     = tgt_ok;
   assign stat.tgt_is_goal = (tgt_cell == goal_x);
   assign stat.sw_last     = sw_last;
   assign stat.scan_last   = (k_ff == 2'd3);

   a_upd_no_decrease: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_write |-> nv >= rd_ff)
      else $error("updated value below stored value");

   a_cur_holds: assert property (@(posedge clock) disable iff (reset)
      !cmd.cur_set |=> $stable(cur_cell_ff))
      else $error("agent cell moved without a set");

   a_best_rises: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |=> best_ff >= $past(best_ff))
      else $error("scan maximum fell");

endmodule

FILE: design/q_learning_grid_update.sv
// Top level of the grid Q-learning update block.
//
//   channel  ports                                    handshake
//   req      start, busy, req_payload                 taken when start && !busy
//   rsp      rsp_valid, rsp_payload                   one-cycle strobe, no back-pressure
//   csr      csr_valid, csr_ready, csr_index, csr_wdata   write on valid && ready
//
// After reset the table is cleared one entry a cycle, all 4*MAX_DIM*MAX_DIM entries, with busy high.
// Init sweeps the whole table the same way, then locates the restart cell.
// Locating a cell subtracts the column count once a cycle.
// Step: locate, four table reads of the next cell, multiply, read and write; the four
// reads are skipped when the next cell is the goal; restart locates twice, rejects end at locate.
// Query: locate plus four table reads of the located cell. One transaction in flight at a time.
// The result strobe lasts one cycle; the receiver cannot stall it.
module q_learning_grid_update #(
   parameter int MAX_DIM    = 8,
   parameter int VALUE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  qlg_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   output qlg_pkg::rsp_type                rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [qlg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qlg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import qlg_pkg::*;

   csr_regs_type regs;
   dp_cmd_type   cmd;
   dp_stat_type  stat;

   qlg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   qlg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_payload.command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   qlg_dpath #(
      .MAX_DIM    (MAX_DIM),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_in    (req_payload),
      .regs      (regs),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_out   (rsp_payload)
   );

endmodule
